// File: sv/imhc_pkg.sv
// imhc_pkg: shared constants and types for the indexed max-heap counter
// no dependencies
`default_nettype none
package imhc_pkg;
  localparam int unsigned HeapDepthDefault = 256;
  localparam int unsigned KeyW = 32;
  localparam int unsigned CountW = 31;
  localparam int unsigned IncW = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic FuncAdd     = 1'b0;
  localparam logic FuncExtract = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdSrchRd, CmdSrchChk, CmdUpdate, CmdAppend, CmdUpRd,
    CmdUpSwap, CmdExRd, CmdExMove, CmdDnRd, CmdDnSwap
  } cmd_e;

  typedef struct packed {
    logic found;      // search hit on current entry
    logic srch_end;   // search index reached entry count
    logic full;
    logic empty;
    logic up_swap;    // child strictly greater than parent
    logic up_top;     // at root
    logic dn_swap;    // a child beats the entry
    logic ex_last;    // heap becomes empty
  } stat_t;
endpackage
`default_nettype wire

// File: sv/imhc_datapath.sv
// imhc_datapath: heap memories, entry count, index registers, compares
// depends on imhc_pkg
`default_nettype none
module imhc_datapath import imhc_pkg::*; #(
  parameter int unsigned HeapDepth = HeapDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_e              cmd_i,
  input  wire logic [KeyW-1:0]   word_key_i,
  input  wire logic [IncW-1:0]   increment_i,
  output stat_t                  stat_o,
  output logic [KeyW-1:0]        max_key_o,
  output logic [CountW-1:0]      max_count_o
);
  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned NW = $clog2(HeapDepth + 1);

  logic [KeyW-1:0]   mem_k [HeapDepth];
  logic [CountW-1:0] mem_c [HeapDepth];

  logic [NW-1:0]     n_q;
  logic [NW-1:0]     pos_q;     // current entry / search index
  logic [KeyW-1:0]   key_q;
  logic [IncW-1:0]   inc_q;
  // read data registers: a = current, b = parent/left, c = right
  logic [KeyW-1:0]   ka_q, kb_q, kc_q;
  logic [CountW-1:0] ca_q, cb_q, cc_q;
  logic [KeyW-1:0]   mk_q;
  logic [CountW-1:0] mc_q;

  logic [NW-1:0] par, lft, rgt, chd;
  logic [NW:0]   l_w, r_w;
  logic [CountW:0] sum;
  logic l_ok, r_ok, take_r;
  assign par = (pos_q - NW'(1)) >> 1;
  assign l_w = {pos_q, 1'b1};
  assign r_w = {pos_q, 1'b0} + (NW+1)'(2);
  assign lft = l_w[NW-1:0];
  assign rgt = r_w[NW-1:0];
  assign l_ok = l_w < {1'b0, n_q};
  assign r_ok = r_w < {1'b0, n_q};
  assign take_r = r_ok && (cc_q > cb_q);
  assign chd = take_r ? rgt : lft;   // chosen child
  assign sum = {1'b0, ca_q} + (CountW+1)'(inc_q);

  always_comb begin
    stat_o.found    = (ka_q == key_q);
    stat_o.srch_end = (pos_q >= n_q);
    stat_o.full     = (n_q == NW'(HeapDepth));
    stat_o.empty    = (n_q == '0);
    stat_o.up_swap  = ca_q > cb_q;
    stat_o.up_top   = (pos_q == '0);
    stat_o.dn_swap  = take_r ? (cc_q > ca_q) : (l_ok && cb_q > ca_q);
    stat_o.ex_last  = (n_q == '0);
  end

  // memory ports: up to two writes or two reads a cycle, reads registered
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CmdSrchRd: begin
        ka_q <= mem_k[pos_q[AW-1:0]];
        ca_q <= mem_c[pos_q[AW-1:0]];
      end
      CmdUpdate: begin
        mem_c[pos_q[AW-1:0]] <= sum[CountW] ? CountMax : sum[CountW-1:0];
        ca_q <= sum[CountW] ? CountMax : sum[CountW-1:0];
      end
      CmdAppend: begin
        mem_k[n_q[AW-1:0]] <= key_q;
        mem_c[n_q[AW-1:0]] <= CountW'(inc_q);
        ka_q <= key_q;
        ca_q <= CountW'(inc_q);
      end
      CmdUpRd: begin
        kb_q <= mem_k[par[AW-1:0]];
        cb_q <= mem_c[par[AW-1:0]];
      end
      CmdUpSwap: begin
        mem_k[par[AW-1:0]] <= ka_q;
        mem_c[par[AW-1:0]] <= ca_q;
        mem_k[pos_q[AW-1:0]] <= kb_q;
        mem_c[pos_q[AW-1:0]] <= cb_q;
      end
      CmdExRd: begin
        mk_q <= mem_k[0];
        mc_q <= mem_c[0];
        ka_q <= mem_k[n_q[AW-1:0] - AW'(1)];
        ca_q <= mem_c[n_q[AW-1:0] - AW'(1)];
      end
      CmdExMove: begin
        mem_k[0] <= ka_q;
        mem_c[0] <= ca_q;
      end
      CmdDnRd: begin
        kb_q <= mem_k[lft[AW-1:0]];
        cb_q <= mem_c[lft[AW-1:0]];
        kc_q <= mem_k[rgt[AW-1:0]];
        cc_q <= mem_c[rgt[AW-1:0]];
      end
      CmdDnSwap: begin
        mem_k[pos_q[AW-1:0]] <= take_r ? kc_q : kb_q;
        mem_c[pos_q[AW-1:0]] <= take_r ? cc_q : cb_q;
        mem_k[chd[AW-1:0]] <= ka_q;
        mem_c[chd[AW-1:0]] <= ca_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      pos_q <= '0;
      key_q <= '0;
      inc_q <= '0;
    end else begin
      case (cmd_i)
        CmdLoad: begin
          key_q <= word_key_i;
          inc_q <= increment_i;
          pos_q <= '0;
        end
        CmdSrchChk: if (!(ka_q == key_q)) pos_q <= pos_q + NW'(1);
        CmdAppend: begin
          pos_q <= n_q;
          n_q   <= n_q + NW'(1);
        end
        CmdUpSwap: pos_q <= par;
        CmdExRd: begin
          n_q   <= n_q - NW'(1);
          pos_q <= '0;
        end
        CmdDnSwap: pos_q <= chd;
        default: ;
      endcase
    end
  end

  assign max_key_o   = mk_q;
  assign max_count_o = mc_q;
endmodule
`default_nettype wire

// File: sv/imhc_ctrl.sv
// imhc_ctrl: sequencer for search, sift up, extract and sift down
// depends on imhc_pkg
`default_nettype none
module imhc_ctrl import imhc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic func_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [1:0] status_o,
  output logic      zero_o,      // clear extracted fields
  input  wire stat_t stat_i,
  output cmd_e      cmd_o
);
  localparam logic [3:0] SIdle = 4'd0, SSrd = 4'd1, SSchk = 4'd2, SUpd = 4'd3,
    SUrd = 4'd4, SUchk = 4'd5, SErd = 4'd6, SEmv = 4'd7, SDrd = 4'd8,
    SDchk = 4'd9, SOut = 4'd10, SAppend = 4'd11;

  logic [3:0] st_q, st_d;
  logic [1:0] stat_q, stat_d;
  logic zero_q, zero_d;

  always_comb begin
    st_d = st_q;
    stat_d = stat_q;
    zero_d = zero_q;
    cmd_o = CmdNone;
    case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o = CmdLoad;
        stat_d = StatusDone;
        zero_d = 1'b1;
        st_d = (func_i == FuncExtract) ? SErd : SSrd;
      end
      SSrd: begin
        if (stat_i.srch_end) begin
          if (stat_i.full) begin
            stat_d = StatusFull;
            st_d = SOut;
          end else st_d = SAppend;
        end else begin
          cmd_o = CmdSrchRd;
          st_d = SSchk;
        end
      end
      SSchk: begin
        cmd_o = CmdSrchChk;
        st_d = stat_i.found ? SUpd : SSrd;
      end
      SUpd: begin
        cmd_o = CmdUpdate;
        st_d = SUrd;
      end
      SAppend: begin
        cmd_o = CmdAppend;
        st_d = SUrd;
      end
      SUrd: begin
        if (stat_i.up_top) st_d = SOut;
        else begin
          cmd_o = CmdUpRd;
          st_d = SUchk;
        end
      end
      SUchk: begin
        if (stat_i.up_swap) begin
          cmd_o = CmdUpSwap;
          st_d = SUrd;
        end else st_d = SOut;
      end
      SErd: begin
        if (stat_i.empty) begin
          stat_d = StatusEmpty;
          st_d = SOut;
        end else begin
          cmd_o = CmdExRd;
          zero_d = 1'b0;
          st_d = SEmv;
        end
      end
      SEmv: begin
        cmd_o = CmdExMove;
        st_d = stat_i.ex_last ? SOut : SDrd;
      end
      SDrd: begin
        cmd_o = CmdDnRd;
        st_d = SDchk;
      end
      SDchk: begin
        if (stat_i.dn_swap) begin
          cmd_o = CmdDnSwap;
          st_d = SDrd;
        end else st_d = SOut;
      end
      SOut: if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      stat_q <= StatusDone;
      zero_q <= 1'b1;
    end else begin
      st_q <= st_d;
      stat_q <= stat_d;
      zero_q <= zero_d;
    end
  end

  assign in_stall_o  = (st_q != SIdle);
  assign out_valid_o = (st_q == SOut);
  assign status_o    = stat_q;
  assign zero_o      = zero_q;
endmodule
`default_nettype wire

// File: sv/indexed_max_heap_counter.sv
// indexed_max_heap_counter: top level, joins sequencer and heap datapath
// depends on imhc_pkg, imhc_ctrl, imhc_datapath
//
// binary max-heap of up to HEAP_DEPTH (key, count) entries held in one memory
// pair. an add transfer searches the stored keys linearly (a read and a check
// state per entry looked at), adds the increment with saturation at 2^31-1
// and sifts the entry up; an unknown key is appended and sifted up, or
// dropped with full status. an extract transfer returns the root, moves the
// last entry up and sifts it down, left child winning ties. one item at a
// time. no clearing pass; the result is held until taken
`default_nettype none
module indexed_max_heap_counter import imhc_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HeapDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              func_i,
  input  wire logic [KeyW-1:0]   word_key_i,
  input  wire logic [IncW-1:0]   increment_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             status_o,
  output logic [KeyW-1:0]        max_key_o,
  output logic [CountW-1:0]      max_count_o
);
  cmd_e  cmd;
  stat_t stat;
  logic  zero;
  logic [KeyW-1:0]   mk;
  logic [CountW-1:0] mc;

  // sequencer
  imhc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .out_valid_o, .out_stall_i, .status_o,
    .zero_o(zero), .stat_i(stat), .cmd_o(cmd)
  );

  // heap storage and compares
  imhc_datapath #(.HeapDepth(HEAP_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .word_key_i, .increment_i,
    .stat_o(stat), .max_key_o(mk), .max_count_o(mc)
  );

  // only a successful extract shows the root
  assign max_key_o   = zero ? '0 : mk;
  assign max_count_o = zero ? '0 : mc;
endmodule
`default_nettype wire
